[hw/rtl/ppmdec_pkg.sv]
// Shared types and constants for the PPM P6 to ARGB4444 decoder.
`default_nettype none
package ppmdec_pkg;

    localparam int DIM_BITS = 16;
    localparam logic [15:0] DIM_MAX = 16'((1 << DIM_BITS) - 1);
    localparam logic [16:0] ACC_MAX = 17'h1FFFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_6 = 8'h36;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [3:0] ALPHA = 4'hF;
    localparam logic [3:0] NIB_MAX = 4'hF;

    localparam logic [1:0] CHAN_R = 2'd0;
    localparam logic [1:0] CHAN_G = 2'd1;
    localparam logic [1:0] CHAN_B = 2'd2;

    typedef enum logic [2:0] {
        K_HEADER    = 3'd0,
        K_PIXEL     = 3'd1,
        K_BAD_MAGIC = 3'd2,
        K_BAD_TOKEN = 3'd3,
        K_ZERO_MAX  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] chan;
        logic [7:0] data;
    } t_job;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ppmdec_front.sv]
// Front end: header parser and pixel channel classifier.
`default_nettype none
module ppmdec_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [7:0]           i_byte,
    output logic                o_job_push,
    output ppmdec_pkg::t_job    o_job,
    output logic [15:0]         o_width,
    output logic [15:0]         o_height,
    output logic [15:0]         o_maxval
);

    typedef enum logic [7:0] {
        P_MAGIC_WS  = 8'b0000_0001,
        P_MAGIC_6   = 8'b0000_0010,
        P_MAGIC_END = 8'b0000_0100,
        P_HDR_WS    = 8'b0000_1000,
        P_NUM       = 8'b0001_0000,
        P_COMMENT   = 8'b0010_0000,
        P_PIXELS    = 8'b0100_0000,
        P_ERROR     = 8'b1000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [16:0] r_acc, n_acc;
    logic [1:0]  r_vidx, n_vidx;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_maxval, n_maxval;
    logic [1:0]  r_chan, n_chan;
    logic [31:0] r_pix, n_pix;

    logic [3:0]  dig;
    logic [20:0] acc10;
    logic [15:0] v_dim;
    logic [15:0] v_max;
    logic        sp;
    logic        dg;

    assign dig   = 4'(i_byte - ppmdec_pkg::CH_ZERO);
    assign acc10 = 21'({r_acc, 3'b000}) + 21'({r_acc, 1'b0}) + 21'(dig);
    assign v_dim = (r_acc > {1'b0, ppmdec_pkg::DIM_MAX}) ? ppmdec_pkg::DIM_MAX : r_acc[15:0];
    assign v_max = r_acc[16] ? 16'hFFFF : r_acc[15:0];
    assign sp    = ppmdec_pkg::is_space(i_byte);
    assign dg    = ppmdec_pkg::is_digit(i_byte);

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_vidx     = r_vidx;
        n_width    = r_width;
        n_height   = r_height;
        n_maxval   = r_maxval;
        n_chan     = r_chan;
        n_pix      = r_pix;
        o_job_push = 1'b0;
        o_job.kind = ppmdec_pkg::K_PIXEL;
        o_job.chan = r_chan;
        o_job.data = i_byte;
        if (i_accept) begin
            case (r_phase)
                P_MAGIC_WS: begin
                    if (!sp) begin
                        if (i_byte == ppmdec_pkg::CH_P) begin
                            n_phase = P_MAGIC_6;
                        end else begin
                            n_phase    = P_ERROR;
                            o_job_push = 1'b1;
                            o_job.kind = ppmdec_pkg::K_BAD_MAGIC;
                        end
                    end
                end
                P_MAGIC_6: begin
                    if (i_byte == ppmdec_pkg::CH_6) begin
                        n_phase = P_MAGIC_END;
                    end else begin
                        n_phase    = P_ERROR;
                        o_job_push = 1'b1;
                        o_job.kind = ppmdec_pkg::K_BAD_MAGIC;
                    end
                end
                P_MAGIC_END: begin
                    if (sp) begin
                        n_phase = P_HDR_WS;
                    end else begin
                        n_phase    = P_ERROR;
                        o_job_push = 1'b1;
                        o_job.kind = ppmdec_pkg::K_BAD_MAGIC;
                    end
                end
                P_HDR_WS: begin
                    if (sp) begin
                        n_phase = P_HDR_WS;
                    end else if (i_byte == ppmdec_pkg::CH_HASH) begin
                        n_phase = P_COMMENT;
                    end else if (dg) begin
                        n_acc   = 17'(dig);
                        n_phase = P_NUM;
                    end else begin
                        n_phase    = P_ERROR;
                        o_job_push = 1'b1;
                        o_job.kind = ppmdec_pkg::K_BAD_TOKEN;
                    end
                end
                P_NUM: begin
                    if (dg) begin
                        n_acc = (acc10 > 21'(ppmdec_pkg::ACC_MAX)) ? ppmdec_pkg::ACC_MAX
                                                                   : acc10[16:0];
                    end else begin
                        n_acc = '0;
                        if (r_vidx == 2'd2) begin
                            n_maxval   = v_max;
                            n_vidx     = 2'd0;
                            o_job_push = 1'b1;
                            if (v_max == 16'd0) begin
                                n_phase    = P_ERROR;
                                o_job.kind = ppmdec_pkg::K_ZERO_MAX;
                            end else begin
                                n_pix      = 32'(r_width) * 32'(r_height);
                                n_chan     = ppmdec_pkg::CHAN_R;
                                n_phase    = P_PIXELS;
                                o_job.kind = ppmdec_pkg::K_HEADER;
                            end
                        end else begin
                            if (r_vidx == 2'd0) begin
                                n_width = v_dim;
                            end else begin
                                n_height = v_dim;
                            end
                            n_vidx = 2'(r_vidx + 2'd1);
                            if (sp) begin
                                n_phase = P_HDR_WS;
                            end else if (i_byte == ppmdec_pkg::CH_HASH) begin
                                n_phase = P_COMMENT;
                            end else begin
                                n_phase    = P_ERROR;
                                o_job_push = 1'b1;
                                o_job.kind = ppmdec_pkg::K_BAD_TOKEN;
                            end
                        end
                    end
                end
                P_COMMENT: begin
                    if (i_byte == ppmdec_pkg::CH_NL) begin
                        n_phase = P_HDR_WS;
                    end
                end
                P_PIXELS: begin
                    if (r_pix != 32'd0) begin
                        o_job_push = 1'b1;
                        if (r_chan == ppmdec_pkg::CHAN_B) begin
                            n_chan = ppmdec_pkg::CHAN_R;
                            n_pix  = r_pix - 32'd1;
                        end else begin
                            n_chan = 2'(r_chan + 2'd1);
                        end
                    end
                end
                P_ERROR: begin
                    n_phase = P_ERROR;
                end
                default: begin
                    n_phase = P_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_MAGIC_WS;
            r_acc    <= '0;
            r_vidx   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_maxval <= '0;
            r_chan   <= '0;
            r_pix    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_vidx   <= n_vidx;
            r_width  <= n_width;
            r_height <= n_height;
            r_maxval <= n_maxval;
            r_chan   <= n_chan;
            r_pix    <= n_pix;
        end
    end

    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_maxval = r_maxval;

endmodule
`default_nettype wire

[hw/rtl/ppmdec_fifo.sv]
// Short job queue between the parser and the channel scaler.
`default_nettype none
module ppmdec_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ppmdec_pkg::t_job    i_data,
    input  wire                 i_pop,
    output ppmdec_pkg::t_job    o_data,
    output logic                o_full,
    output logic                o_valid
);

    ppmdec_pkg::t_job              r_mem [ppmdec_pkg::Q_DEPTH];
    logic [ppmdec_pkg::Q_AW-1:0]   r_wp, r_rp;
    logic [ppmdec_pkg::Q_AW:0]     r_cnt;
    logic                          wr, rd;

    assign o_full  = (r_cnt == (ppmdec_pkg::Q_AW + 1)'(ppmdec_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ppmdec_back.sv]
// Back end: iterative channel scaler, pixel assembly and output register.
`default_nettype none
module ppmdec_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ppmdec_pkg::t_job    i_job,
    input  wire                 i_job_valid,
    output logic                o_job_pop,
    input  wire [15:0]          i_maxval,
    input  wire                 i_pop,
    output logic                o_empty,
    output logic [2:0]          o_kind,
    output logic [15:0]         o_word
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_den, n_den;
    logic [3:0]  r_q, n_q;
    logic [1:0]  r_k, n_k;
    logic        r_sat, n_sat;
    logic [1:0]  r_chan, n_chan;
    logic [7:0]  r_part, n_part;
    logic        r_valid, n_valid;
    ppmdec_pkg::t_kind r_kind, n_kind;
    logic [15:0] r_word, n_word;

    logic        out_free;
    logic [16:0] b30;
    logic [16:0] num;
    logic [16:0] den;
    logic [20:0] shifted;
    logic        ge;
    logic [3:0]  nib;

    assign out_free = !r_valid || i_pop;
    assign b30      = 17'({i_job.data, 5'b0_0000}) - 17'({i_job.data, 1'b0});
    assign num      = b30 + {1'b0, i_maxval};
    assign den      = {i_maxval, 1'b0};
    assign shifted  = {4'b0000, r_den} << r_k;
    assign ge       = {4'b0000, r_rem} >= shifted;
    assign nib      = r_sat ? ppmdec_pkg::NIB_MAX : {r_q[3:1], ge};

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_den     = r_den;
        n_q       = r_q;
        n_k       = r_k;
        n_sat     = r_sat;
        n_chan    = r_chan;
        n_part    = r_part;
        n_valid   = r_valid && !i_pop;
        n_kind    = r_kind;
        n_word    = r_word;
        o_job_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.kind != ppmdec_pkg::K_PIXEL) begin
                        if (out_free) begin
                            o_job_pop = 1'b1;
                            n_valid   = 1'b1;
                            n_kind    = i_job.kind;
                            n_word    = '0;
                        end
                    end else begin
                        o_job_pop = 1'b1;
                        n_rem     = num;
                        n_den     = den;
                        n_sat     = {4'b0000, num} >= {den, 4'b0000};
                        n_q       = '0;
                        n_k       = 2'd3;
                        n_chan    = i_job.chan;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_k != 2'd0) begin
                    if (ge) begin
                        n_rem      = r_rem - shifted[16:0];
                        n_q[r_k]   = 1'b1;
                    end
                    n_k = r_k - 2'd1;
                end else begin
                    case (r_chan)
                        ppmdec_pkg::CHAN_R: begin
                            n_part  = {nib, 4'b0000};
                            n_state = S_IDLE;
                        end
                        ppmdec_pkg::CHAN_G: begin
                            n_part  = {r_part[7:4], nib};
                            n_state = S_IDLE;
                        end
                        default: begin
                            if (out_free) begin
                                n_valid = 1'b1;
                                n_kind  = ppmdec_pkg::K_PIXEL;
                                n_word  = {ppmdec_pkg::ALPHA, r_part, nib};
                                n_state = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_part  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_part  <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_k    <= n_k;
        r_sat  <= n_sat;
        r_chan <= n_chan;
        r_kind <= n_kind;
        r_word <= n_word;
    end

    assign o_empty = !r_valid;
    assign o_kind  = r_kind;
    assign o_word  = r_word;

endmodule
`default_nettype wire

[hw/rtl/ppm_p6_to_argb4444_decoder_unit.sv]
// Top level of the PPM P6 stream to ARGB4444 pixel decoder.
// Input queue side: drive i_in_byte and raise i_push; a byte is taken at a
// rising edge with i_push high and o_full low. Result queue side: while
// o_empty is low, o_out_kind, o_img_width, o_img_height and o_pixel_word show
// the oldest result, and it is taken at an edge with i_pop high.
// The parser handles one byte per cycle while the queue is not full and
// hands header results, errors and pixel channel bytes to a four-entry job
// queue. The scaler takes one channel byte at a time: a load step, then four
// restoring divide steps by 2*maxval; it takes no new byte until the last
// step is done. Header results and errors skip the divide steps. A pixel
// result reaches the output register once the divide steps of its blue byte
// are done and the output register is free.
// Reset (synchronous, active low) returns the parser to the magic search,
// clears the queue and drops any waiting result.
// When the receiver stalls, the output register holds its word, the scaler
// holds its finished blue channel, the queue fills and o_full rises.
`default_nettype none
module ppm_p6_to_argb4444_decoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire [7:0]   i_in_byte,
    output logic        o_empty,
    input  wire         i_pop,
    output logic [2:0]  o_out_kind,
    output logic [15:0] o_img_width,
    output logic [15:0] o_img_height,
    output logic [15:0] o_pixel_word
);

    ppmdec_pkg::t_job q_in, q_out;
    logic             q_push, q_pop, q_full, q_valid;
    logic [15:0]      maxval;
    logic             accept;

    assign accept = i_push && !q_full;
    assign o_full = q_full;

    ppmdec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_in_byte),
        .o_job_push (q_push),
        .o_job      (q_in),
        .o_width    (o_img_width),
        .o_height   (o_img_height),
        .o_maxval   (maxval)
    );

    ppmdec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    ppmdec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_maxval    (maxval),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_kind      (o_out_kind),
        .o_word      (o_pixel_word)
    );

endmodule
`default_nettype wire
